[hw/rtl/obm_pkg.sv]
package obm_pkg;

    localparam int TableEntriesDefault = 32;
    localparam int TickerCountDefault  = 256;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] trade_number;
        logic [15:0] buyer;
        logic [15:0] seller;
        logic [31:0] resting_time;
        logic [31:0] incoming_time;
        logic [31:0] fill_price;
        logic [7:0]  instrument;
        logic [23:0] fill_amount;
        logic        book_full;
        logic        last;
    } t_result;

endpackage

[hw/rtl/obm_out_reg.sv]
module obm_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  obm_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output obm_pkg::t_result o_data
);
    import obm_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_data))
        else $error("result changed under stall");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid)
        else $error("result lost");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("empty register not ready");
endmodule

[hw/rtl/order_book_matcher.sv]
// Limit order book matcher.
// Input channel (i_valid/o_ready) takes one order per transfer: side, trader,
// ticker, time, price, quantity. Output channel (o_valid/i_ready) gives
// trade fills, each with o_last low, then one done item with o_last high.
// The block holds one order at a time and drops o_ready until its done item
// has been handed to the output register.
// Per order: an accept step, a cancel sweep over all TABLE_ENTRIES entries,
// then for each fill a search sweep over the table plus an emit step, then
// one more search sweep that finds no match (and also finds the lowest
// free entry), then a rest/done step. When a fill uses up the order, the
// final search sweep is skipped; a zero quantity goes from the cancel sweep
// straight to the done step. The single table compare unit visits one entry
// a cycle.
// Each result waits in a one-deep output register; while the receiver stalls
// the sequencer holds.
// Reset (synchronous, active low) clears every entry valid bit and both
// counters; the block is ready in the first cycle after reset.
module order_book_matcher #(
    parameter int TABLE_ENTRIES = obm_pkg::TableEntriesDefault,
    parameter int TICKER_COUNT  = obm_pkg::TickerCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_is_sell,
    input  logic [15:0] i_trader,
    input  logic [7:0]  i_ticker,
    input  logic [31:0] i_order_time,
    input  logic [31:0] i_limit_price,
    input  logic [23:0] i_quantity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [31:0] o_trade_number,
    output logic [15:0] o_buyer,
    output logic [15:0] o_seller,
    output logic [31:0] o_resting_time,
    output logic [31:0] o_incoming_time,
    output logic [31:0] o_fill_price,
    output logic [7:0]  o_instrument,
    output logic [23:0] o_fill_amount,
    output logic        o_book_full,
    output logic        o_last
);
    import obm_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {S_IDLE, S_CANCEL, S_SEARCH, S_FILL, S_DONE} t_state;

    function automatic logic [7:0] wrap_ticker(input logic [7:0] t);
        logic [7:0] w;
        w = t;
        for (int k = 0; k < 256; k++) begin
            if (t == 8'(k)) begin
                w = 8'(k % TICKER_COUNT);
            end
        end
        return w;
    endfunction

    t_state      r_state;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic        r_side;
    logic [15:0] r_trader;
    logic [7:0]  r_ticker;
    logic [31:0] r_time;
    logic [31:0] r_price;
    logic [23:0] r_remain;
    logic        r_found;
    logic [IW-1:0] r_best;
    logic [31:0] r_best_age;
    logic [23:0] r_best_amount;
    logic [15:0] r_best_trader;
    logic [31:0] r_best_time;
    logic        r_free_ok;
    logic [IW-1:0] r_free;
    logic [31:0] r_order_count;
    logic [31:0] r_trade_count;
    logic [TABLE_ENTRIES-1:0] r_valid_bits;

    logic        mem_side   [TABLE_ENTRIES];
    logic [15:0] mem_trader [TABLE_ENTRIES];
    logic [7:0]  mem_ticker [TABLE_ENTRIES];
    logic [31:0] mem_price  [TABLE_ENTRIES];
    logic [23:0] mem_amount [TABLE_ENTRIES];
    logic [31:0] mem_time   [TABLE_ENTRIES];
    logic [31:0] mem_seq    [TABLE_ENTRIES];

    logic        r_rd_side;
    logic [15:0] r_rd_trader;
    logic [7:0]  r_rd_ticker;
    logic [31:0] r_rd_price;
    logic [23:0] r_rd_amount;
    logic [31:0] r_rd_time;
    logic [31:0] r_rd_seq;

    t_result w_res;
    logic    w_res_valid;
    logic    w_out_ready;
    t_result w_out;

    logic        c_valid;
    logic        c_side;
    logic [15:0] c_trader;
    logic [7:0]  c_ticker;
    logic [31:0] c_price;
    logic [23:0] c_amount;
    logic [31:0] c_time;
    logic [31:0] c_seq;
    logic [31:0] c_age;
    logic        c_match;
    logic [7:0]  w_ticker_in;
    logic [23:0] b_amount;
    logic [15:0] b_trader;
    logic [31:0] b_time;
    logic        b_partial;
    logic [23:0] b_take;

    always_comb begin
        c_valid  = r_valid_bits[r_idx];
        c_side   = r_rd_side;
        c_trader = r_rd_trader;
        c_ticker = r_rd_ticker;
        c_price  = r_rd_price;
        c_amount = r_rd_amount;
        c_time   = r_rd_time;
        c_seq    = r_rd_seq;
        c_age    = r_order_count - c_seq;
        c_match  = c_valid && c_side != r_side && c_ticker == r_ticker
                   && c_price == r_price;
        b_amount = r_best_amount;
        b_trader = r_best_trader;
        b_time   = r_best_time;
        b_partial = b_amount > r_remain;
        b_take   = b_partial ? r_remain : b_amount;
        w_ticker_in = wrap_ticker(i_ticker);
    end

    always_comb begin
        case (r_state)
            S_IDLE:   n_idx = i_valid ? '0 : r_idx;
            S_CANCEL: n_idx = (r_idx == LastIdx) ? '0 : r_idx + 1'b1;
            S_SEARCH: n_idx = (r_idx == LastIdx) ? '0 : r_idx + 1'b1;
            default:  n_idx = r_idx;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        w_res       = '0;
        w_res_valid = 1'b0;
        w_res.incoming_time = r_time;
        w_res.fill_price    = r_price;
        w_res.instrument    = r_ticker;
        if (r_state == S_FILL) begin
            w_res_valid        = 1'b1;
            w_res.kind         = KIND_FILL;
            w_res.trade_number = r_trade_count;
            w_res.buyer        = r_side ? b_trader : r_trader;
            w_res.seller       = r_side ? r_trader : b_trader;
            w_res.resting_time = b_time;
            w_res.fill_amount  = b_take;
        end else if (r_state == S_DONE) begin
            w_res_valid       = 1'b1;
            w_res.kind        = KIND_DONE;
            w_res.buyer       = r_side ? 16'd0 : r_trader;
            w_res.seller      = r_side ? r_trader : 16'd0;
            w_res.fill_amount = r_remain;
            w_res.book_full   = (r_remain != '0) && !r_free_ok;
            w_res.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid_bits  <= '0;
            r_order_count <= '0;
            r_trade_count <= '0;
            r_idx         <= '0;
        end else begin
            r_idx       <= n_idx;
            r_rd_side   <= mem_side[n_idx];
            r_rd_trader <= mem_trader[n_idx];
            r_rd_ticker <= mem_ticker[n_idx];
            r_rd_price  <= mem_price[n_idx];
            r_rd_amount <= mem_amount[n_idx];
            r_rd_time   <= mem_time[n_idx];
            r_rd_seq    <= mem_seq[n_idx];
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_side   <= i_is_sell;
                        r_trader <= i_trader;
                        r_ticker <= w_ticker_in;
                        r_time   <= i_order_time;
                        r_price  <= i_limit_price;
                        r_remain <= i_quantity;
                        r_state  <= S_CANCEL;
                    end
                end
                S_CANCEL: begin
                    if (c_valid && c_trader == r_trader && c_ticker == r_ticker) begin
                        r_valid_bits[r_idx] <= 1'b0;
                    end
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    if (r_idx == LastIdx) begin
                        r_order_count <= r_order_count + 1'b1;
                        r_state       <= (r_remain == '0) ? S_DONE : S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (c_match && (!r_found || c_age > r_best_age)) begin
                        r_found       <= 1'b1;
                        r_best        <= r_idx;
                        r_best_age    <= c_age;
                        r_best_amount <= c_amount;
                        r_best_trader <= c_trader;
                        r_best_time   <= c_time;
                    end
                    if (!c_valid && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_idx;
                    end
                    if (r_idx == LastIdx) begin
                        r_state <= (r_found || c_match) ? S_FILL : S_DONE;
                    end
                end
                S_FILL: begin
                    if (w_out_ready) begin
                        r_trade_count <= r_trade_count + 1'b1;
                        r_found       <= 1'b0;
                        r_free_ok     <= 1'b0;
                        if (b_partial) begin
                            mem_amount[r_best] <= b_amount - r_remain;
                            r_remain <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_valid_bits[r_best] <= 1'b0;
                            r_remain <= r_remain - b_amount;
                            r_state  <= (r_remain == b_amount) ? S_DONE : S_SEARCH;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_ready) begin
                        if (r_remain != '0 && r_free_ok) begin
                            r_valid_bits[r_free] <= 1'b1;
                            mem_side[r_free]     <= r_side;
                            mem_trader[r_free]   <= r_trader;
                            mem_ticker[r_free]   <= r_ticker;
                            mem_price[r_free]    <= r_price;
                            mem_amount[r_free]   <= r_remain;
                            mem_time[r_free]     <= r_time;
                            mem_seq[r_free]      <= r_order_count;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    obm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_out_ready),
        .i_data  (w_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_kind          = w_out.kind;
    assign o_trade_number  = w_out.trade_number;
    assign o_buyer         = w_out.buyer;
    assign o_seller        = w_out.seller;
    assign o_resting_time  = w_out.resting_time;
    assign o_incoming_time = w_out.incoming_time;
    assign o_fill_price    = w_out.fill_price;
    assign o_instrument    = w_out.instrument;
    assign o_fill_amount   = w_out.fill_amount;
    assign o_book_full     = w_out.book_full;
    assign o_last          = w_out.last;

    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> r_valid_bits[r_best])
        else $error("fill from empty entry");
    a_fill_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> r_remain != '0)
        else $error("fill with nothing left");
    a_trades: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL && w_out_ready |=> r_trade_count == $past(r_trade_count) + 1'b1)
        else $error("trade count skipped");
endmodule

[sim/tb_order_book_matcher.sv]
module tb_order_book_matcher;
    timeunit 1ns;
    timeprecision 1ps;
    import obm_pkg::*;

    localparam int Entries = TableEntriesDefault;
    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic        is_sell;
        logic [15:0] trader;
        logic [7:0]  ticker;
        logic [31:0] order_time;
        logic [31:0] limit_price;
        logic [23:0] quantity;
    } t_order;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_is_sell;
    logic [15:0] i_trader;
    logic [7:0]  i_ticker;
    logic [31:0] i_order_time;
    logic [31:0] i_limit_price;
    logic [23:0] i_quantity;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [31:0] o_trade_number;
    logic [15:0] o_buyer;
    logic [15:0] o_seller;
    logic [31:0] o_resting_time;
    logic [31:0] o_incoming_time;
    logic [31:0] o_fill_price;
    logic [7:0]  o_instrument;
    logic [23:0] o_fill_amount;
    logic        o_book_full;
    logic        o_last;
    t_result     got;
    logic        o_ready_seen;

    order_book_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_is_sell(i_is_sell), .i_trader(i_trader), .i_ticker(i_ticker),
        .i_order_time(i_order_time), .i_limit_price(i_limit_price),
        .i_quantity(i_quantity), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_trade_number(o_trade_number), .o_buyer(o_buyer),
        .o_seller(o_seller), .o_resting_time(o_resting_time),
        .o_incoming_time(o_incoming_time), .o_fill_price(o_fill_price),
        .o_instrument(o_instrument), .o_fill_amount(o_fill_amount),
        .o_book_full(o_book_full), .o_last(o_last)
    );

    assign got = {o_kind, o_trade_number, o_buyer, o_seller, o_resting_time,
                  o_incoming_time, o_fill_price, o_instrument, o_fill_amount,
                  o_book_full, o_last};

    // book shadow
    logic        bk_valid [Entries];
    logic        bk_side  [Entries];
    logic [15:0] bk_trader[Entries];
    logic [7:0]  bk_ticker[Entries];
    logic [31:0] bk_price [Entries];
    logic [23:0] bk_amount[Entries];
    logic [31:0] bk_time  [Entries];
    logic [31:0] bk_seq   [Entries];
    logic [31:0] order_cnt;
    logic [31:0] trade_cnt;

    t_order  pending_orders[$];
    t_result expected_fills[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;
    int      errors;
    int      idle_cycles;
    int      orders_sent;
    int      results_seen;
    int      fills_seen;
    int      full_seen;

    task automatic queue_order(input t_order o);
        pending_orders.insert(pending_orders.size(), o);
    endtask

    task automatic queue_result(input t_result r);
        expected_fills.insert(expected_fills.size(), r);
    endtask

    task automatic match_order(input t_order o);
        logic [23:0] remain;
        logic [23:0] amt;
        logic [31:0] age;
        logic [31:0] best_age;
        logic        full;
        int          best;
        int          slot;
        t_result     r;
        remain = o.quantity;
        full = 1'b0;
        for (int i = 0; i < Entries; i++)
            if (bk_valid[i] && bk_trader[i] == o.trader && bk_ticker[i] == o.ticker)
                bk_valid[i] = 1'b0;
        order_cnt = order_cnt + 32'd1;
        while (remain != '0) begin
            best = -1;
            best_age = '0;
            for (int i = 0; i < Entries; i++) begin
                if (bk_valid[i] && bk_side[i] != o.is_sell && bk_ticker[i] == o.ticker
                        && bk_price[i] == o.limit_price) begin
                    age = order_cnt - bk_seq[i];
                    if (best < 0 || age > best_age) begin
                        best = i;
                        best_age = age;
                    end
                end
            end
            if (best < 0) break;
            if (bk_amount[best] > remain) begin
                amt = remain;
                bk_amount[best] = bk_amount[best] - remain;
                remain = '0;
            end else begin
                amt = bk_amount[best];
                remain = remain - amt;
                bk_valid[best] = 1'b0;
            end
            r = '0;
            r.kind = KIND_FILL;
            r.trade_number = trade_cnt;
            r.buyer = o.is_sell ? bk_trader[best] : o.trader;
            r.seller = o.is_sell ? o.trader : bk_trader[best];
            r.resting_time = bk_time[best];
            r.incoming_time = o.order_time;
            r.fill_price = o.limit_price;
            r.instrument = o.ticker;
            r.fill_amount = amt;
            queue_result(r);
            trade_cnt = trade_cnt + 32'd1;
        end
        if (remain != '0) begin
            slot = -1;
            for (int i = 0; i < Entries; i++)
                if (!bk_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
                full = 1'b1;
            end else begin
                bk_valid[slot] = 1'b1;
                bk_side[slot] = o.is_sell;
                bk_trader[slot] = o.trader;
                bk_ticker[slot] = o.ticker;
                bk_price[slot] = o.limit_price;
                bk_amount[slot] = remain;
                bk_time[slot] = o.order_time;
                bk_seq[slot] = order_cnt;
            end
        end
        r = '0;
        r.kind = KIND_DONE;
        r.buyer = o.is_sell ? 16'd0 : o.trader;
        r.seller = o.is_sell ? o.trader : 16'd0;
        r.incoming_time = o.order_time;
        r.fill_price = o.limit_price;
        r.instrument = o.ticker;
        r.fill_amount = remain;
        r.book_full = full;
        r.last = 1'b1;
        queue_result(r);
    endtask

    function automatic t_order make_order(logic s, logic [15:0] t, logic [7:0] k,
                                          logic [31:0] tm, logic [31:0] p,
                                          logic [23:0] q);
        t_order o;
        o.is_sell = s;
        o.trader = t;
        o.ticker = k;
        o.order_time = tm;
        o.limit_price = p;
        o.quantity = q;
        return o;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready_seen) begin
            if (pending_orders.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                t_order o;
                o = pending_orders.pop_front();
                i_valid <= 1'b1;
                {i_is_sell, i_trader, i_ticker, i_order_time, i_limit_price, i_quantity}
                    <= o;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            match_order({i_is_sell, i_trader, i_ticker, i_order_time, i_limit_price,
                         i_quantity});
            orders_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_result e;
            results_seen++;
            if (expected_fills.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                e = expected_fills.pop_front();
                if (e.kind == KIND_FILL) fills_seen++;
                if (e.book_full) full_seen++;
                if (got.kind !== e.kind) begin
                    $display("%0t kind exp %h got %h", $time, e.kind, got.kind); errors++;
                end
                if (got.trade_number !== e.trade_number) begin
                    $display("%0t trade_number exp %h got %h", $time, e.trade_number,
                             got.trade_number); errors++;
                end
                if (got.buyer !== e.buyer) begin
                    $display("%0t buyer exp %h got %h", $time, e.buyer, got.buyer); errors++;
                end
                if (got.seller !== e.seller) begin
                    $display("%0t seller exp %h got %h", $time, e.seller, got.seller);
                    errors++;
                end
                if (got.resting_time !== e.resting_time) begin
                    $display("%0t resting_time exp %h got %h", $time, e.resting_time,
                             got.resting_time); errors++;
                end
                if (got.incoming_time !== e.incoming_time) begin
                    $display("%0t incoming_time exp %h got %h", $time, e.incoming_time,
                             got.incoming_time); errors++;
                end
                if (got.fill_price !== e.fill_price) begin
                    $display("%0t fill_price exp %h got %h", $time, e.fill_price,
                             got.fill_price); errors++;
                end
                if (got.instrument !== e.instrument) begin
                    $display("%0t instrument exp %h got %h", $time, e.instrument,
                             got.instrument); errors++;
                end
                if (got.fill_amount !== e.fill_amount) begin
                    $display("%0t fill_amount exp %h got %h", $time, e.fill_amount,
                             got.fill_amount); errors++;
                end
                if (got.book_full !== e.book_full) begin
                    $display("%0t book_full exp %h got %h", $time, e.book_full,
                             got.book_full); errors++;
                end
                if (got.last !== e.last) begin
                    $display("%0t last exp %h got %h", $time, e.last, got.last); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transfer in %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_random_phase(int count);
        t_order o;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9, 0) < 8) begin
                // small trader, ticker, price pools so orders collide and match
                o = make_order(1'($urandom_range(1, 0)), 16'($urandom_range(7, 0)),
                               8'($urandom_range(2, 0)), $urandom(),
                               32'(100 + $urandom_range(3, 0)),
                               24'($urandom_range(40, 1)));
                if ($urandom_range(19, 0) == 0) o.quantity = '0;
            end else begin
                o = make_order(1'($urandom_range(1, 0)), 16'($urandom()), 8'($urandom()),
                               $urandom(), $urandom(), 24'($urandom()));
            end
            queue_order(o);
        end
    endtask

    task automatic wait_drained();
        while (pending_orders.size() != 0 || i_valid || expected_fills.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_order o;
        errors = 0; idle_cycles = 0; orders_sent = 0; results_seen = 0;
        fills_seen = 0; full_seen = 0; hold_cycles = 0;
        send_idle_pct = 16; recv_idle_pct = 54;
        order_cnt = '0; trade_cnt = '0;
        for (int i = 0; i < Entries; i++) bk_valid[i] = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; o_ready_seen = 1'b0;
        {i_is_sell, i_trader, i_ticker, i_order_time, i_limit_price, i_quantity} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_order(make_order(1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 24'h0));
        queue_order(make_order(1'b1, 16'hFFFF, 8'hFF, 32'hFFFFFFFF,
                               32'hFFFFFFFF, 24'hFFFFFF));
        queue_order(make_order(1'b0, 16'h0001, 8'hFF, 32'h1, 32'hFFFFFFFF,
                               24'h000001));
        queue_order(make_order(1'b0, 16'h0002, 8'hFF, 32'h2, 32'hFFFFFFFF,
                               24'hFFFFFF));
        queue_order(make_order(1'b1, 16'h0010, 8'h05, 32'h10, 32'd50, 24'd10));
        queue_order(make_order(1'b1, 16'h0011, 8'h05, 32'h11, 32'd50, 24'd7));
        queue_order(make_order(1'b0, 16'h0020, 8'h05, 32'h20, 32'd50, 24'd12));
        queue_order(make_order(1'b0, 16'h0020, 8'h05, 32'h21, 32'd50, 24'd3));
        queue_order(make_order(1'b0, 16'h0020, 8'h05, 32'h22, 32'd51, 24'd0));
        queue_order(make_order(1'b1, 16'h0030, 8'h05, 32'h23, 32'd60, 24'd4));
        queue_order(make_order(1'b1, 16'h0030, 8'h05, 32'h24, 32'd61, 24'd4));
        // fill the table, then overflow it, then sweep it with one large order
        for (int i = 0; i < 34; i++)
            queue_order(make_order(1'b1, 16'(16'h0100 + i), 8'h07, 32'(i),
                                   32'd77, 24'd2));
        queue_order(make_order(1'b0, 16'h0200, 8'h07, 32'h99, 32'd77,
                               24'hFFFFFF));
        add_random_phase(38);
        wait_drained();

        send_idle_pct = 54; recv_idle_pct = 16;
        add_random_phase(38);
        @(negedge i_clk);
        hold_cycles = 400;
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        add_random_phase(38);
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("orders %0d, results %0d, fills %0d, table-full drops %0d",
                 orders_sent, results_seen, fills_seen, full_seen);
        $display("three throttling phases incl. a long output hold, mismatches %0d",
                 errors);
        if (errors == 0 && expected_fills.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
